// ----- rtl/gsp_pkg.sv -----
package gsp_pkg;

    // Frame lengths in bytes. The extended frame is never shorter than the short one.
    localparam int unsigned SHORT_FRAME_BYTES = 9;
    localparam int unsigned FULL_FRAME_BYTES  = 21;
    localparam int unsigned FULL_LEN_BYTES    =
        (FULL_FRAME_BYTES > SHORT_FRAME_BYTES) ? FULL_FRAME_BYTES : SHORT_FRAME_BYTES;

    localparam logic [4:0]  SHORT_LEN = 5'(SHORT_FRAME_BYTES);
    localparam logic [4:0]  FULL_LEN  = 5'(FULL_LEN_BYTES);

    localparam logic [7:0]  CMD_START    = 8'h01;
    localparam logic [7:0]  CMD_POLL     = 8'h42;
    localparam logic [7:0]  ID_EXTENDED  = 8'h79;
    localparam logic [7:0]  ID_TYPE_MASK = 8'hF0;
    localparam logic [7:0]  ID_TYPE_OK   = 8'h70;
    localparam logic [15:0] BUTTONS_NONE = 16'hFFFF;

    localparam logic [4:0]  BYTE_START = 5'd0;
    localparam logic [4:0]  BYTE_ID    = 5'd1;
    localparam logic [4:0]  BYTE_BTN_LO = 5'd3;
    localparam logic [4:0]  BYTE_BTN_HI = 5'd4;

    localparam logic [7:0]  RST_CLOCK_LOW  = 8'd5;
    localparam logic [7:0]  RST_CLOCK_HIGH = 8'd5;
    localparam logic [7:0]  RST_BYTE_GAP   = 8'd18;
    localparam logic [3:0]  RST_MAX_TRIES  = 4'd5;

    typedef enum logic [1:0] {
        CFG_CLOCK_LOW  = 2'd0,
        CFG_CLOCK_HIGH = 2'd1,
        CFG_BYTE_GAP   = 2'd2,
        CFG_MAX_TRIES  = 2'd3
    } t_cfg_idx;

    typedef enum logic [5:0] {
        PH_IDLE     = 6'b000001,
        PH_ATT_GAP  = 6'b000010,
        PH_CLK_LOW  = 6'b000100,
        PH_CLK_HIGH = 6'b001000,
        PH_BYTE_GAP = 6'b010000,
        PH_RETRY    = 6'b100000
    } t_phase;

    typedef struct packed {
        logic       start_req;
        logic       data_in;
    } t_req;

    typedef struct packed {
        logic        command_line;
        logic        clock_line;
        logic        attention_line;
        logic        busy_res;
        logic        done_res;
        logic        success;
        logic [15:0] buttons;
        logic [7:0]  mode_id;
    } t_res;

    typedef struct packed {
        logic [7:0] clock_low_ticks;
        logic [7:0] clock_high_ticks;
        logic [7:0] byte_gap_ticks;
        logic [3:0] max_tries;
    } t_cfg;

    typedef struct packed {
        t_phase      phase;
        logic [7:0]  tick_count;
        logic [2:0]  bit_index;
        logic [4:0]  byte_index;
        logic [3:0]  try_count;
        logic [7:0]  shift_in;
        logic [7:0]  id_byte;
        logic [15:0] button_bytes;
        logic        res_success;
        logic [15:0] res_buttons;
        logic [7:0]  res_mode_id;
    } t_state;

    function automatic logic [7:0] send_byte(logic [4:0] byte_index);
        logic [7:0] b;
        b = 8'h00;
        if (byte_index == BYTE_START) begin
            b = CMD_START;
        end else if (byte_index == BYTE_ID) begin
            b = CMD_POLL;
        end
        return b;
    endfunction

endpackage

// ----- rtl/gsp_step.sv -----
module gsp_step import gsp_pkg::*; (
    input  t_state i_state,
    input  t_cfg   i_cfg,
    input  t_req   i_req,
    output t_state o_state,
    output t_res   o_res
);

    logic [7:0] low_m1;
    logic [7:0] high_m1;
    logic [3:0] tries_lim;
    logic [7:0] cmd_byte;
    logic       done;
    t_state     s;

    // A zero clock time counts as one tick, zero tries as one attempt.
    assign low_m1    = (i_cfg.clock_low_ticks == 8'd0) ? 8'd0 : i_cfg.clock_low_ticks - 8'd1;
    assign high_m1   = (i_cfg.clock_high_ticks == 8'd0) ? 8'd0 : i_cfg.clock_high_ticks - 8'd1;
    assign tries_lim = (i_cfg.max_tries == 4'd0) ? 4'd1 : i_cfg.max_tries;

    function automatic t_state f_start_byte(t_state st, logic [7:0] lm1);
        t_state r;
        r            = st;
        r.bit_index  = 3'd0;
        r.shift_in   = 8'd0;
        r.phase      = PH_CLK_LOW;
        r.tick_count = lm1;
        return r;
    endfunction

    function automatic t_state f_start_attempt(t_state st, logic [7:0] gap, logic [7:0] lm1);
        t_state r;
        r            = st;
        r.byte_index = 5'd0;
        if (gap == 8'd0) begin
            r = f_start_byte(r, lm1);
        end else begin
            r.phase      = PH_ATT_GAP;
            r.tick_count = gap - 8'd1;
        end
        return r;
    endfunction

    // Ends the frame: either reports the poll or schedules another attempt.
    function automatic t_state f_finish(t_state st, logic [3:0] lim, output logic fin);
        t_state r;
        logic   ok;
        r           = st;
        ok          = (st.id_byte & ID_TYPE_MASK) == ID_TYPE_OK;
        r.res_mode_id = st.id_byte;
        r.try_count = st.try_count + 4'd1;
        r.tick_count = 8'd0;
        if (ok || r.try_count >= lim) begin
            r.res_success = ok;
            r.res_buttons = ok ? st.button_bytes : BUTTONS_NONE;
            r.phase       = PH_IDLE;
            fin           = 1'b1;
        end else begin
            r.phase = PH_RETRY;
            fin     = 1'b0;
        end
        return r;
    endfunction

    function automatic t_state f_after_gap(t_state st, logic [7:0] lm1, logic [3:0] lim,
                                           output logic fin);
        t_state     r;
        logic [4:0] len;
        len = (st.id_byte == ID_EXTENDED) ? FULL_LEN : SHORT_LEN;
        fin = 1'b0;
        if (st.byte_index >= len) begin
            r = f_finish(st, lim, fin);
        end else begin
            r = f_start_byte(st, lm1);
        end
        return r;
    endfunction

    always_comb begin
        s    = i_state;
        done = 1'b0;
        if (i_state.phase == PH_IDLE) begin
            if (i_req.start_req) begin
                s.try_count = 4'd0;
                s = f_start_attempt(s, i_cfg.byte_gap_ticks, low_m1);
            end
        end else if (i_state.tick_count != 8'd0) begin
            s.tick_count = i_state.tick_count - 8'd1;
        end else begin
            unique case (i_state.phase)
                PH_ATT_GAP: begin
                    s = f_start_byte(s, low_m1);
                end
                PH_CLK_LOW: begin
                    if (i_req.data_in) begin
                        s.shift_in = i_state.shift_in | (8'd1 << i_state.bit_index);
                    end
                    s.phase      = PH_CLK_HIGH;
                    s.tick_count = high_m1;
                end
                PH_CLK_HIGH: begin
                    if (i_state.bit_index == 3'd7) begin
                        if (i_state.byte_index == BYTE_ID) begin
                            s.id_byte = i_state.shift_in;
                        end else if (i_state.byte_index == BYTE_BTN_LO) begin
                            s.button_bytes[7:0] = i_state.shift_in;
                        end else if (i_state.byte_index == BYTE_BTN_HI) begin
                            s.button_bytes[15:8] = i_state.shift_in;
                        end
                        s.byte_index = i_state.byte_index + 5'd1;
                        if (i_cfg.byte_gap_ticks == 8'd0) begin
                            s = f_after_gap(s, low_m1, tries_lim, done);
                        end else begin
                            s.phase      = PH_BYTE_GAP;
                            s.tick_count = i_cfg.byte_gap_ticks - 8'd1;
                        end
                    end else begin
                        s.bit_index  = i_state.bit_index + 3'd1;
                        s.phase      = PH_CLK_LOW;
                        s.tick_count = low_m1;
                    end
                end
                PH_BYTE_GAP: begin
                    s = f_after_gap(s, low_m1, tries_lim, done);
                end
                PH_RETRY: begin
                    s = f_start_attempt(s, i_cfg.byte_gap_ticks, low_m1);
                end
                default: begin
                    s.phase = PH_IDLE;
                end
            endcase
        end
    end

    assign cmd_byte = send_byte(s.byte_index);
    assign o_state  = s;

    always_comb begin
        o_res                = '0;
        o_res.command_line   = 1'b1;
        o_res.clock_line     = 1'b1;
        o_res.attention_line = 1'b1;
        if ((s.phase == PH_CLK_LOW) || (s.phase == PH_CLK_HIGH)) begin
            o_res.command_line   = cmd_byte[s.bit_index];
            o_res.clock_line     = (s.phase == PH_CLK_HIGH);
            o_res.attention_line = 1'b0;
        end else if ((s.phase == PH_ATT_GAP) || (s.phase == PH_BYTE_GAP)) begin
            o_res.attention_line = 1'b0;
        end
        o_res.busy_res = (s.phase != PH_IDLE);
        o_res.done_res = done;
        o_res.success  = s.res_success;
        o_res.buttons  = s.res_buttons;
        o_res.mode_id  = s.res_mode_id;
    end

endmodule

// ----- rtl/gamepad_serial_poller.sv -----
// The result of an accepted tick request is registered in the output register.
// Throughput: one tick request per cycle when not stalled; a tick's update is one pass of logic.
// The request side stalls only while an unaccepted result sits in the output register.
// Reset (synchronous, active low) returns the poller to idle with the default timing
// registers, buttons 0xFFFF, mode id 0, and an empty output register.
module gamepad_serial_poller import gsp_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_req_valid,
    output logic       o_req_ready,
    input  t_req       i_req,
    output logic       o_res_valid,
    input  logic       i_res_ready,
    output t_res       o_res,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_idx,
    input  logic [7:0] i_cfg_data
);

    // Poller state and the timing registers. Every accepted request is one timing
    // tick: the step logic advances the bus phase by that tick and the resulting
    // line levels and status are captured in the output register.
    t_state r_state;
    t_state n_state;
    t_cfg   r_cfg;
    t_res   r_res;
    t_res   n_res;
    logic   r_res_valid;
    logic   req_accept;

    gsp_step u_step (
        .i_state (r_state),
        .i_cfg   (r_cfg),
        .i_req   (i_req),
        .o_state (n_state),
        .o_res   (n_res)
    );

    // The output register frees up in the same cycle it is drained, so a steady
    // stream of ticks flows at full rate as long as the consumer keeps up.
    assign o_req_ready = !r_res_valid || i_res_ready;
    assign req_accept  = i_req_valid && o_req_ready;
    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.clock_low_ticks  <= RST_CLOCK_LOW;
            r_cfg.clock_high_ticks <= RST_CLOCK_HIGH;
            r_cfg.byte_gap_ticks   <= RST_BYTE_GAP;
            r_cfg.max_tries        <= RST_MAX_TRIES;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_CLOCK_LOW:  r_cfg.clock_low_ticks  <= i_cfg_data;
                CFG_CLOCK_HIGH: r_cfg.clock_high_ticks <= i_cfg_data;
                CFG_BYTE_GAP:   r_cfg.byte_gap_ticks   <= i_cfg_data;
                CFG_MAX_TRIES:  r_cfg.max_tries        <= i_cfg_data[3:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase        <= PH_IDLE;
            r_state.tick_count   <= 8'd0;
            r_state.bit_index    <= 3'd0;
            r_state.byte_index   <= 5'd0;
            r_state.try_count    <= 4'd0;
            r_state.shift_in     <= 8'd0;
            r_state.id_byte      <= 8'd0;
            r_state.button_bytes <= BUTTONS_NONE;
            r_state.res_success  <= 1'b0;
            r_state.res_buttons  <= BUTTONS_NONE;
            r_state.res_mode_id  <= 8'd0;
            r_res_valid          <= 1'b0;
        end else begin
            if (req_accept) begin
                r_state     <= n_state;
                r_res_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_res_valid <= 1'b0;
            end
        end
    end

    // Result payload needs no reset; it is qualified by the valid flag.
    always_ff @(posedge i_clk) begin
        if (req_accept) begin
            r_res <= n_res;
        end
    end

`ifndef ASSERT_OFF
    // A finishing tick always reports the poller as no longer busy.
    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_res_valid |-> !(r_res.done_res && r_res.busy_res))
        else $error("done reported while still busy");

    // When idle, all bus lines are released high.
    a_idle_lines_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_res_valid && !r_res.busy_res) |->
            (r_res.command_line && r_res.clock_line && r_res.attention_line))
        else $error("bus line driven low while idle");

    // A start request taken while idle always begins a poll.
    a_start_begins_poll: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (req_accept && (r_state.phase == PH_IDLE) && i_req.start_req) |=>
            (r_state.phase != PH_IDLE))
        else $error("start request did not begin a poll");

    // A failed poll reports no buttons pressed.
    a_fail_buttons: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_res_valid && r_res.done_res && !r_res.success) |->
            (r_res.buttons == BUTTONS_NONE))
        else $error("failed poll reported button data");
`endif

endmodule
